// File: sv/hdfs_pkg.sv
// ----------------------------------------------------------------------------
// hdfs_pkg
// Shared types, codes and helpers of the heater duty floor schedule unit.
// ----------------------------------------------------------------------------
package hdfs_pkg;

   localparam int QBITS = 15;

   typedef enum logic [2:0] {
      REG_RANGE = 3'd0,
      REG_THR   = 3'd1,
      REG_BELOW = 3'd2,
      REG_HOLD  = 3'd3,
      REG_AMAX  = 3'd4,
      REG_FS    = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      RSN_NONE  = 2'd0,
      RSN_BELOW = 2'd1,
      RSN_ABOVE = 2'd2,
      RSN_HOLD  = 2'd3
   } reason_type;

   // endpoint pair of the final interpolation
   typedef enum logic [1:0] {
      SEL_NONE  = 2'd0,
      SEL_MID   = 2'd1,
      SEL_CLOSE = 2'd2,
      SEL_ABOVE = 2'd3
   } sel_type;

   typedef enum logic [1:0] {
      W_ZERO = 2'd0,
      W_DIV  = 2'd1,
      W_FULL = 2'd2
   } wmode_type;

   typedef struct packed {
      logic [31:0] range;
      logic [63:0] thr;
      logic [63:0] below;
      logic [63:0] hold;
      logic [15:0] amax;
      logic [15:0] fs;
   } cfg_type;

   typedef struct packed {
      sel_type     sel;
      wmode_type   wmode;
      logic        n_div;
      logic [15:0] n_const;
      logic        hold_en;
   } ctl_type;

   // rem < den always holds
   typedef struct packed {
      logic [15:0]      rem;
      logic [15:0]      den;
      logic [QBITS-1:0] quo;
   } div_type;

   function automatic div_type div_step(input div_type d);
      div_type     r;
      logic [16:0] t;
      begin
         t = {d.rem, 1'b0};
         r = d;
         if (t >= {1'b0, d.den}) begin
            r.rem = 16'(t - {1'b0, d.den});
            r.quo = {d.quo[QBITS-2:0], 1'b1};
         end else begin
            r.rem = t[15:0];
            r.quo = {d.quo[QBITS-2:0], 1'b0};
         end
         return r;
      end
   endfunction

endpackage

// File: sv/hdfs_if.sv
// ----------------------------------------------------------------------------
// hdfs interfaces
// Request, response and register write channels.
// ----------------------------------------------------------------------------
interface hdfs_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] temperature;
   logic signed [15:0] target_temp;
   modport source (output valid, temperature, target_temp, input ready);
   modport sink (input valid, temperature, target_temp, output ready);
endinterface

interface hdfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] floor_duty;
   logic [1:0]  floor_reason;
   modport source (output valid, floor_duty, floor_reason, input ready);
   modport sink (input valid, floor_duty, floor_reason, output ready);
endinterface

interface hdfs_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: sv/hdfs_front.sv
// ----------------------------------------------------------------------------
// hdfs_front
// Error decode, segment selection and divider operand setup.
// ----------------------------------------------------------------------------
module hdfs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [15:0] temperature,
   input  logic signed [15:0] target_temp,
   input  hdfs_pkg::cfg_type  cfg,
   output logic               valid_ff,
   output hdfs_pkg::ctl_type  ctl_ff,
   output hdfs_pkg::div_type  ndiv_ff,
   output hdfs_pkg::div_type  wdiv_ff
);

   logic signed [17:0] err, ea, lo, hi, rng, d;
   logic signed [17:0] far, mid, close, band, eff;
   hdfs_pkg::ctl_type  ctl_in;
   hdfs_pkg::div_type  ndiv_in, wdiv_in;
   logic [15:0]        wnum, wden;

   always_comb begin
      err   = 18'(target_temp) - 18'(temperature);
      ea    = -err;
      lo    = 18'($signed(cfg.range[15:0]));
      hi    = 18'($signed(cfg.range[31:16]));
      rng   = hi - lo;
      d     = 18'(target_temp) - lo;
      far   = 18'($signed(cfg.thr[15:0]));
      mid   = 18'($signed(cfg.thr[31:16]));
      close = 18'($signed(cfg.thr[47:32]));
      band  = 18'($signed(cfg.thr[63:48]));
      eff   = (err < close) ? close : err;

      ctl_in.n_div   = 1'b0;
      ctl_in.n_const = 16'd0;
      ndiv_in.rem    = 16'd0;
      ndiv_in.den    = 16'd1;
      ndiv_in.quo    = '0;
      if (rng <= 0) begin
         ctl_in.n_const = 16'd16384;
      end else if (d <= 0) begin
         ctl_in.n_const = 16'd0;
      end else if (d >= rng) begin
         ctl_in.n_const = 16'd32768;
      end else begin
         ctl_in.n_div = 1'b1;
         ndiv_in.rem  = d[15:0];
         ndiv_in.den  = rng[15:0];
      end

      wnum           = 16'd0;
      wden           = 16'd1;
      ctl_in.hold_en = 1'b0;
      ctl_in.sel     = hdfs_pkg::SEL_NONE;
      ctl_in.wmode   = hdfs_pkg::W_ZERO;
      if (err > 0) begin
         ctl_in.hold_en = (err <= band);
         if (err >= far) begin
            ctl_in.sel   = hdfs_pkg::SEL_MID;
            ctl_in.wmode = hdfs_pkg::W_FULL;
         end else if (err >= mid) begin
            ctl_in.sel = hdfs_pkg::SEL_MID;
            if (far > mid) begin
               ctl_in.wmode = hdfs_pkg::W_DIV;
               wnum         = 16'(err - mid);
               wden         = 16'(far - mid);
            end
         end else begin
            ctl_in.sel = hdfs_pkg::SEL_CLOSE;
            if (mid > close) begin
               ctl_in.wmode = hdfs_pkg::W_DIV;
               wnum         = 16'(eff - close);
               wden         = 16'(mid - close);
            end
         end
      end else if (ea <= far) begin
         ctl_in.sel = hdfs_pkg::SEL_ABOVE;
         if (ea >= far || far <= 0) begin
            ctl_in.wmode = hdfs_pkg::W_FULL;
         end else begin
            ctl_in.wmode = hdfs_pkg::W_DIV;
            wnum         = ea[15:0];
            wden         = far[15:0];
         end
      end
      wdiv_in.rem = wnum;
      wdiv_in.den = wden;
      wdiv_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         ctl_ff  <= ctl_in;
         ndiv_ff <= ndiv_in;
         wdiv_ff <= wdiv_in;
      end
   end

endmodule

// File: sv/hdfs_div_stage.sv
// ----------------------------------------------------------------------------
// hdfs_div_stage
// One restoring step of the setpoint and weight dividers.
// ----------------------------------------------------------------------------
module hdfs_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_in,
   input  hdfs_pkg::ctl_type ctl_in,
   input  hdfs_pkg::div_type ndiv_in,
   input  hdfs_pkg::div_type wdiv_in,
   output logic              valid_ff,
   output hdfs_pkg::ctl_type ctl_ff,
   output hdfs_pkg::div_type ndiv_ff,
   output hdfs_pkg::div_type wdiv_ff
);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         ctl_ff  <= ctl_in;
         ndiv_ff <= hdfs_pkg::div_step(ndiv_in);
         wdiv_ff <= hdfs_pkg::div_step(wdiv_in);
      end
   end

endmodule

// File: sv/hdfs_back.sv
// ----------------------------------------------------------------------------
// hdfs_back
// Endpoint interpolation, floor selection and duty scaling.
// ----------------------------------------------------------------------------
module hdfs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         valid_in,
   input  hdfs_pkg::ctl_type            ctl_in,
   input  logic [hdfs_pkg::QBITS-1:0]   nq,
   input  logic [hdfs_pkg::QBITS-1:0]   wq,
   input  hdfs_pkg::cfg_type            cfg,
   output logic                         valid_ff,
   output logic                         b5_valid,
   output logic [15:0]                  duty_ff,
   output hdfs_pkg::reason_type         reason_ff
);

   // stage 1: endpoint products
   logic [15:0]        n, w;
   logic signed [33:0] pfar_in, pclose_in, phold_in;
   logic signed [33:0] pfar_ff, pclose_ff, phold_ff;
   logic [15:0]        w1_ff;
   hdfs_pkg::ctl_type  c1_ff;
   logic               v1_ff;
   // stage 2: endpoints
   logic [15:0]        ffar, fclose, fhold, base, a_in, b_in;
   logic signed [18:0] sfar, sclose, shold;
   logic signed [16:0] braw;
   logic [15:0]        a2_ff, b2_ff, w2_ff, h2_ff;
   hdfs_pkg::ctl_type  c2_ff;
   logic               v2_ff;
   // stage 3: final product
   logic signed [33:0] p3_in, p3_ff;
   logic [15:0]        a3_ff, h3_ff;
   hdfs_pkg::ctl_type  c3_ff;
   logic               v3_ff;
   // stage 4: selection
   logic signed [18:0] sf;
   logic [15:0]        f, best_in, best_ff;
   hdfs_pkg::reason_type rsn_in, r4_ff, r5_ff;
   logic               v4_ff;
   // stage 5: scaling
   logic [31:0]        prod_ff;
   logic               v5_ff;
   logic [16:0]        q;

   always_comb begin
      n = ctl_in.n_div ? {1'b0, nq} : ctl_in.n_const;
      case (ctl_in.wmode)
         hdfs_pkg::W_DIV:  w = {1'b0, wq};
         hdfs_pkg::W_FULL: w = 16'd32768;
         default:          w = 16'd0;
      endcase
      pfar_in   = (34'($signed({1'b0, cfg.below[31:16]})) -
                   34'($signed({1'b0, cfg.below[15:0]}))) * 34'($signed({1'b0, n}));
      pclose_in = (34'($signed({1'b0, cfg.below[63:48]})) -
                   34'($signed({1'b0, cfg.below[47:32]}))) * 34'($signed({1'b0, n}));
      phold_in  = (34'($signed({1'b0, cfg.hold[31:16]})) -
                   34'($signed({1'b0, cfg.hold[15:0]}))) * 34'($signed({1'b0, n}));
   end

   always_comb begin
      sfar   = 19'($signed({1'b0, cfg.below[15:0]})) + $signed(pfar_ff[33:15]);
      sclose = 19'($signed({1'b0, cfg.below[47:32]})) + $signed(pclose_ff[33:15]);
      shold  = 19'($signed({1'b0, cfg.hold[15:0]})) + $signed(phold_ff[33:15]);
      ffar   = sfar[15:0];
      fclose = sclose[15:0];
      fhold  = shold[15:0];
      braw   = $signed({1'b0, fhold}) - $signed({1'b0, cfg.hold[47:32]});
      base   = (braw < $signed({1'b0, cfg.hold[63:48]})) ? cfg.hold[63:48] : braw[15:0];
      case (c1_ff.sel)
         hdfs_pkg::SEL_MID: begin
            a_in = ffar;
            b_in = 16'd32768;
         end
         hdfs_pkg::SEL_CLOSE: begin
            a_in = fclose;
            b_in = ffar;
         end
         hdfs_pkg::SEL_ABOVE: begin
            a_in = base;
            b_in = cfg.amax;
         end
         default: begin
            a_in = 16'd0;
            b_in = 16'd0;
         end
      endcase
   end

   always_comb begin
      p3_in = (34'($signed({1'b0, b2_ff})) - 34'($signed({1'b0, a2_ff}))) *
              34'($signed({1'b0, w2_ff}));
   end

   always_comb begin
      sf      = 19'($signed({1'b0, a3_ff})) + $signed(p3_ff[33:15]);
      f       = sf[15:0];
      best_in = 16'd0;
      rsn_in  = hdfs_pkg::RSN_NONE;
      case (c3_ff.sel)
         hdfs_pkg::SEL_MID, hdfs_pkg::SEL_CLOSE: begin
            if (f != 16'd0) begin
               best_in = f;
               rsn_in  = hdfs_pkg::RSN_BELOW;
            end
            if (c3_ff.hold_en && h3_ff > best_in) begin
               best_in = h3_ff;
               rsn_in  = hdfs_pkg::RSN_HOLD;
            end
         end
         hdfs_pkg::SEL_ABOVE: begin
            if (f != 16'd0) begin
               best_in = f;
               rsn_in  = hdfs_pkg::RSN_ABOVE;
            end
         end
         default: begin
            best_in = 16'd0;
         end
      endcase
   end

   assign q        = prod_ff[31:15];
   assign b5_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= valid_in;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         valid_ff <= v5_ff;
      end
      if (en) begin
         pfar_ff   <= pfar_in;
         pclose_ff <= pclose_in;
         phold_ff  <= phold_in;
         w1_ff     <= w;
         c1_ff     <= ctl_in;
         a2_ff     <= a_in;
         b2_ff     <= b_in;
         w2_ff     <= w1_ff;
         h2_ff     <= fhold;
         c2_ff     <= c1_ff;
         p3_ff     <= p3_in;
         a3_ff     <= a2_ff;
         h3_ff     <= h2_ff;
         c3_ff     <= c2_ff;
         best_ff   <= best_in;
         r4_ff     <= rsn_in;
         prod_ff   <= best_ff * cfg.fs;
         r5_ff     <= r4_ff;
         duty_ff   <= q[16] ? 16'hFFFF : q[15:0];
         reason_ff <= r5_ff;
      end
   end

endmodule

// File: sv/heater_duty_floor_schedule_unit.sv
// Throughput: one item per cycle while the output is not stalled; the two
// 15-step restoring dividers (setpoint normalization, segment weight) are fully pipelined.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears all valid bits and loads register reset values; no clearing pass.
// ----------------------------------------------------------------------------
// heater_duty_floor_schedule_unit
// Minimum heater duty and reason code from temperature and setpoint.
// ----------------------------------------------------------------------------
module heater_duty_floor_schedule_unit (
   input logic       clock,
   input logic       reset,
   hdfs_req_if.sink   req_chan,
   hdfs_rsp_if.source rsp_chan,
   hdfs_csr_if.sink   csr_chan
);

   localparam int NSTG = hdfs_pkg::QBITS;

   hdfs_pkg::cfg_type    cfg_ff;
   logic                 en;
   logic                 v [0:NSTG];
   hdfs_pkg::ctl_type    c [0:NSTG];
   hdfs_pkg::div_type    nd [0:NSTG];
   hdfs_pkg::div_type    wd [0:NSTG];
   logic                 out_valid, b5_valid;
   logic [15:0]          duty;
   hdfs_pkg::reason_type reason;

   assign en             = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range <= '0;
         cfg_ff.thr   <= '0;
         cfg_ff.below <= '0;
         cfg_ff.hold  <= '0;
         cfg_ff.amax  <= '0;
         cfg_ff.fs    <= 16'd1023;
      end else if (csr_chan.valid) begin
         case (hdfs_pkg::reg_idx_type'(csr_chan.index))
            hdfs_pkg::REG_RANGE: cfg_ff.range <= csr_chan.data[31:0];
            hdfs_pkg::REG_THR:   cfg_ff.thr   <= csr_chan.data;
            hdfs_pkg::REG_BELOW: cfg_ff.below <= csr_chan.data;
            hdfs_pkg::REG_HOLD:  cfg_ff.hold  <= csr_chan.data;
            hdfs_pkg::REG_AMAX:  cfg_ff.amax  <= csr_chan.data[15:0];
            hdfs_pkg::REG_FS:    cfg_ff.fs    <= csr_chan.data[15:0];
            default: ;
         endcase
      end
   end

   hdfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_chan.valid),
      .temperature (req_chan.temperature),
      .target_temp (req_chan.target_temp),
      .cfg         (cfg_ff),
      .valid_ff    (v[0]),
      .ctl_ff      (c[0]),
      .ndiv_ff     (nd[0]),
      .wdiv_ff     (wd[0])
   );

   for (genvar i = 0; i < NSTG; i++) begin : g_div
      hdfs_div_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .valid_in (v[i]),
         .ctl_in   (c[i]),
         .ndiv_in  (nd[i]),
         .wdiv_in  (wd[i]),
         .valid_ff (v[i+1]),
         .ctl_ff   (c[i+1]),
         .ndiv_ff  (nd[i+1]),
         .wdiv_ff  (wd[i+1])
      );
   end

   hdfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (v[NSTG]),
      .ctl_in    (c[NSTG]),
      .nq        (nd[NSTG].quo),
      .wq        (wd[NSTG].quo),
      .cfg       (cfg_ff),
      .valid_ff  (out_valid),
      .b5_valid  (b5_valid),
      .duty_ff   (duty),
      .reason_ff (reason)
   );

   assign rsp_chan.valid        = out_valid;
   assign rsp_chan.floor_duty   = duty;
   assign rsp_chan.floor_reason = reason;

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && reason == hdfs_pkg::RSN_NONE |-> duty == 16'd0)
      else $error("reason none with nonzero duty");

   a_rise_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid) |-> $past(b5_valid))
      else $error("result appeared without a pipeline item");

   a_fs_write: assert property (@(posedge clock) disable iff (reset)
      csr_chan.valid && csr_chan.index == hdfs_pkg::REG_FS |=>
      cfg_ff.fs == $past(csr_chan.data[15:0]))
      else $error("full scale write lost");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> v[NSTG] == $past(v[NSTG]) && b5_valid == $past(b5_valid))
      else $error("pipeline moved during stall");

endmodule

// File: test/heater_duty_floor_schedule_unit_tb.sv
// ----------------------------------------------------------------------------
// heater_duty_floor_schedule_unit_tb
// Drives temperature and setpoint items through the unit under several
// register settings, predicts each duty floor and reason in a scoreboard,
// and checks every result in order under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module heater_duty_floor_schedule_unit_tb;

   localparam int LATENCY = 21;
   localparam longint Q1 = 32768;
   localparam longint QH = 16384;

   typedef struct {
      logic [15:0]          duty;
      hdfs_pkg::reason_type reason;
   } floor_res_type;

   class floor_board;
      logic [63:0]   r_range, r_thr, r_below, r_hold, r_amax, r_fs;
      floor_res_type pending[$];
      int            errors;

      function void reset_regs();
         r_range = 0; r_thr = 0; r_below = 0; r_hold = 0; r_amax = 0; r_fs = 1023;
      endfunction

      function void write_reg(hdfs_pkg::reg_idx_type idx, logic [63:0] v);
         case (idx)
            hdfs_pkg::REG_RANGE: r_range = v[31:0];
            hdfs_pkg::REG_THR:   r_thr = v;
            hdfs_pkg::REG_BELOW: r_below = v;
            hdfs_pkg::REG_HOLD:  r_hold = v;
            hdfs_pkg::REG_AMAX:  r_amax = v[15:0];
            hdfs_pkg::REG_FS:    r_fs = v[15:0];
            default: ;
         endcase
      endfunction

      function longint sf(logic [63:0] w, int k);
         logic signed [15:0] s;
         s = w[16*k +: 16];
         return longint'(s);
      endfunction

      function longint uf(logic [63:0] w, int k);
         return longint'({48'd0, w[16*k +: 16]});
      endfunction

      function longint lerp(longint a, longint b, longint t);
         longint x, q;
         x = (b - a) * t;
         q = x / Q1;
         if (x < 0 && x % Q1 != 0) q = q - 1;
         return a + q;
      endfunction

      function longint wt(longint num, longint den);
         return (num * Q1) / den;
      endfunction

      function longint norm_sp(longint sp);
         longint lo, rng, d;
         lo = sf(r_range, 0);
         rng = sf(r_range, 1) - lo;
         d = sp - lo;
         if (rng <= 0) return QH;
         if (d <= 0) return 0;
         if (d >= rng) return Q1;
         return wt(d, rng);
      endfunction

      function longint below_fl(longint e, longint n);
         longint far, mid, cl, ffar, fcl, eff;
         far = sf(r_thr, 0); mid = sf(r_thr, 1); cl = sf(r_thr, 2);
         ffar = lerp(uf(r_below, 0), uf(r_below, 1), n);
         fcl = lerp(uf(r_below, 2), uf(r_below, 3), n);
         if (e >= far) return Q1;
         if (e >= mid) begin
            if (far - mid <= 0) return ffar;
            return lerp(ffar, Q1, wt(e - mid, far - mid));
         end
         eff = (e < cl) ? cl : e;
         if (mid - cl <= 0) return fcl;
         return lerp(fcl, ffar, wt(eff - cl, mid - cl));
      endfunction

      function longint above_fl(longint ea, longint n);
         longint far, base, amin;
         far = sf(r_thr, 0);
         base = lerp(uf(r_hold, 0), uf(r_hold, 1), n) - uf(r_hold, 2);
         amin = uf(r_hold, 3);
         if (base < amin) base = amin;
         if (ea >= far || far <= 0) return longint'(r_amax[15:0]);
         return lerp(base, longint'(r_amax[15:0]), wt(ea, far));
      endfunction

      function void note_item(logic signed [15:0] temp, logic signed [15:0] sp);
         longint t, s, n, e, best, f, duty;
         floor_res_type r;
         t = temp; s = sp;
         n = norm_sp(s);
         e = s - t;
         best = 0;
         r.reason = hdfs_pkg::RSN_NONE;
         if (t < s) begin
            f = below_fl(e, n);
            if (f > best) begin best = f; r.reason = hdfs_pkg::RSN_BELOW; end
            if (e <= sf(r_thr, 3)) begin
               f = lerp(uf(r_hold, 0), uf(r_hold, 1), n);
               if (f > best) begin best = f; r.reason = hdfs_pkg::RSN_HOLD; end
            end
         end else if (-e <= sf(r_thr, 0)) begin
            f = above_fl(-e, n);
            if (f > best) begin best = f; r.reason = hdfs_pkg::RSN_ABOVE; end
         end
         duty = (best * longint'(r_fs[15:0])) / Q1;
         if (duty > 65535) duty = 65535;
         r.duty = duty[15:0];
         pending.push_back(r);
      endfunction

      function void check_result(logic [15:0] duty, logic [1:0] reason);
         floor_res_type x;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result duty=%0d reason=%0d", duty, reason);
            return;
         end
         x = pending.pop_front();
         if (duty !== x.duty || reason !== x.reason) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp duty=%0d reason=%0d got duty=%0d reason=%0d",
                        x.duty, x.reason, duty, reason);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   hdfs_req_if req_chan();
   hdfs_rsp_if rsp_chan();
   hdfs_csr_if csr_chan();

   heater_duty_floor_schedule_unit u_top (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   floor_board board = new();
   int  cycle_cnt = 0;
   bit  long_hold = 0;
   int  stall_mode = 0;

   initial begin
      req_chan.valid = 0; req_chan.temperature = 0; req_chan.target_temp = 0;
      rsp_chan.ready = 0;
      csr_chan.valid = 0; csr_chan.index = hdfs_pkg::REG_RANGE; csr_chan.data = 0;
   end

   // result sink with its own stall pattern
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (reset) rsp_chan.ready <= 0;
      else if (long_hold) rsp_chan.ready <= 0;
      else case (stall_mode)
         0: rsp_chan.ready <= 1;
         1: rsp_chan.ready <= ($urandom_range(3) != 0);
         default: rsp_chan.ready <= ($urandom_range(2) == 0);
      endcase
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_result(rsp_chan.floor_duty, rsp_chan.floor_reason);
   end

   always @(posedge clock) begin
      if (cycle_cnt > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_csr(hdfs_pkg::reg_idx_type idx, logic [63:0] v);
      csr_chan.valid <= 1; csr_chan.index <= idx; csr_chan.data <= v;
      do @(posedge clock); while (!csr_chan.ready);
      board.write_reg(idx, v);
      csr_chan.valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   int burst_left = 0;
   task automatic send_item(logic signed [15:0] temp, logic signed [15:0] sp);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(4);
         if (gap != 0) begin
            req_chan.valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_chan.valid <= 1; req_chan.temperature <= temp; req_chan.target_temp <= sp;
      do @(posedge clock); while (!req_chan.ready);
      board.note_item(temp, sp);
   endtask

   task automatic idle_req();
      req_chan.valid <= 0;
      burst_left = 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] frac();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'($urandom);
         default: return 16'($urandom_range(32768));
      endcase
   endfunction

   task automatic random_config(int kind);
      logic signed [15:0] lo, hi, far, mid, cl, hb;
      lo = 16'($urandom_range(400)) - 16'sd50;
      hi = lo + 16'($urandom_range(600));
      far = 16'($urandom_range(150, 300)); mid = 16'($urandom_range(60, 150));
      cl = 16'($urandom_range(0, 60)); hb = 16'($urandom_range(0, 80));
      if (kind == 1) begin
         hi = lo; mid = far; cl = mid + 16'sd5;
      end else if (kind == 2) begin
         lo = 16'sh8000; hi = 16'sh7fff; far = 16'sh8000; mid = 16'sh7fff;
         cl = 16'sh8000; hb = 16'sh7fff;
      end else if (kind == 3) begin
         lo = 16'($urandom); hi = 16'($urandom); far = 16'($urandom);
         mid = 16'($urandom); cl = 16'($urandom); hb = 16'($urandom);
      end
      write_csr(hdfs_pkg::REG_RANGE, {32'($urandom), hi, lo});
      write_csr(hdfs_pkg::REG_THR, {hb, cl, mid, far});
      write_csr(hdfs_pkg::REG_BELOW, {frac(), frac(), frac(), frac()});
      write_csr(hdfs_pkg::REG_HOLD, {frac(), frac(), frac(), frac()});
      write_csr(hdfs_pkg::REG_AMAX,
                kind == 2 ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
      case (kind)
         2: write_csr(hdfs_pkg::REG_FS, 64'h0000_0000_0000_FFFF);
         1: write_csr(hdfs_pkg::REG_FS, 64'd1);
         default: write_csr(hdfs_pkg::REG_FS, 64'($urandom_range(1, 65535)));
      endcase
   endtask

   task automatic random_item(int rng);
      logic signed [15:0] sp, d;
      if ($urandom_range(9) == 0) begin
         send_item(16'($urandom), 16'($urandom));
      end else begin
         sp = 16'($urandom_range(700)) - 16'sd100;
         d = 16'($urandom_range(2 * rng)) - 16'(rng);
         send_item(sp - d, sp);
      end
   endtask

   initial begin
      board.reset_regs();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset registers, then field extremes and segment cases
      send_item(16'sh8000, 16'sh7fff);
      send_item(16'sh7fff, 16'sh8000);
      send_item(16'sd0, 16'sd0);
      idle_req();
      drain();
      write_csr(hdfs_pkg::REG_RANGE, {16'sd500, 16'sd100});
      write_csr(hdfs_pkg::REG_THR, {16'sd20, 16'sd10, 16'sd50, 16'sd200});
      write_csr(hdfs_pkg::REG_BELOW, {16'd20000, 16'd8000, 16'd30000, 16'd16000});
      write_csr(hdfs_pkg::REG_HOLD, {16'd3000, 16'd5000, 16'd12000, 16'd9000});
      write_csr(hdfs_pkg::REG_AMAX, 64'd2000);
      write_csr(hdfs_pkg::REG_FS, 64'd1000);
      send_item(16'sd300, 16'sd300);  // at setpoint
      send_item(16'sd295, 16'sd300);  // below close, hold band
      send_item(16'sd285, 16'sd300);  // close..mid
      send_item(16'sd200, 16'sd300);  // mid..far
      send_item(16'sd100, 16'sd300);  // at far
      send_item(16'sd310, 16'sd300);  // above
      send_item(16'sd500, 16'sd300);  // above at far
      send_item(16'sd501, 16'sd300);  // far above
      send_item(16'sd0, 16'sd50);     // setpoint under range
      send_item(16'sd0, 16'sd900);    // setpoint over range
      send_item(16'sh8000, 16'sh7fff);
      send_item(16'sh7fff, 16'sh8000);
      send_item(16'shffff, 16'sh0000);
      idle_req();
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         stall_mode = ph % 3;
         random_config(ph < 4 ? ph : 0);
         for (int i = 0; i < 100; i++) begin
            random_item(ph == 3 ? 30000 : 350);
            if (ph == 2 && i == 30) begin
               long_hold = 1;
               fork
                  begin repeat (200) @(posedge clock); long_hold = 0; end
               join_none
            end
            if (i == 60) begin
               idle_req();
               while (board.pending.size() != 0) @(posedge clock);
            end
         end
         idle_req();
         drain();
      end

      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// File: filelist.f
sv/hdfs_pkg.sv
sv/hdfs_if.sv
sv/hdfs_front.sv
sv/hdfs_div_stage.sv
sv/hdfs_back.sv
sv/heater_duty_floor_schedule_unit.sv
test/heater_duty_floor_schedule_unit_tb.sv
